// ===== hdl/keyed_event_suppression_table_unit_assert.svh =====
// Assertion macros for the keyed event suppression table.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef KEYED_EVENT_SUPPRESSION_TABLE_UNIT_ASSERT_SVH
`define KEYED_EVENT_SUPPRESSION_TABLE_UNIT_ASSERT_SVH

// Check that is held off while reset is asserted.
`define KEST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also applies during reset.
`define KEST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/kest_pkg.sv =====
// Shared constants and types for the keyed event suppression table.
// No dependencies; imported by every module of the block.
package kest_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  // match fields of one table entry
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] rule;
    logic [15:0] rev;
  } kest_key_t;

  // tracking fields of one table entry
  typedef struct packed {
    logic [31:0] count;
    logic [31:0] stamp;
  } kest_trk_t;

  // access request to one of the table memories
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
  } kest_mem_req_t;

endpackage

// ===== hdl/kest_key_mem.sv =====
// Key/rule/revision memory of the suppression table with registered read and
// a compare of the read entry against the event being searched. Uses kest_pkg.
module kest_key_mem import kest_pkg::*; (
  input  logic          clk,
  input  kest_mem_req_t req,
  input  kest_key_t     wr_data,
  input  kest_key_t     cmp_key,
  output logic          match
);

  kest_key_t mem [TABLE_DEPTH];
  kest_key_t rd_q_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  assign match = (rd_q_r == cmp_key);

endmodule

// ===== hdl/kest_trk_mem.sv =====
// Count/stamp memory of the suppression table, registered read that holds
// while no read is issued. Uses kest_pkg.
module kest_trk_mem import kest_pkg::*; (
  input  logic          clk,
  input  kest_mem_req_t req,
  input  kest_trk_t     wr_data,
  output kest_trk_t     rd_data
);

  kest_trk_t mem [TABLE_DEPTH];
  kest_trk_t rd_q_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule

// ===== hdl/keyed_event_suppression_table_unit.sv =====
// Keyed event suppression table: one event in, one verdict out.
// Input channel in_* (valid/ready) carries key hash, rule id and revision,
// pass limit, window and current time. Result channel out_* (valid/ready)
// carries pass_event, hit, inserted, table_full and the suppression total.
// An event is taken only while no other event is being searched. The search
// reads one table entry per cycle from the key memory, in index order.
// A hit goes from the scan to the hit update, a miss (no match among the used
// entries, used = entries in use, at most 64) to miss handling; either way the
// verdict then waits in the emit state until the output register can take it.
// A finished verdict sits in the output register; the next event is accepted
// while it waits, and that event's verdict holds in the block until the
// receiver takes the earlier one.
// Reset (rst_n low, synchronous) empties the table (entry count zero) and
// clears the suppression total; no clearing pass is needed, entries beyond
// the count are never read.
// Depends on kest_pkg, kest_key_mem, kest_trk_mem and the assertion header.
`include "keyed_event_suppression_table_unit_assert.svh"

module keyed_event_suppression_table_unit import kest_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_key_hash,
  input  logic [31:0] in_rule_id,
  input  logic [15:0] in_rule_revision,
  input  logic [31:0] in_pass_limit,
  input  logic [31:0] in_window_seconds,
  input  logic [31:0] in_now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_pass_event,
  output logic        out_hit,
  output logic        out_inserted,
  output logic        out_table_full,
  output logic [31:0] out_suppressed_total_out
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_MISS   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [31:0]      total_r, total_nxt;
  logic             out_valid_r, out_valid_nxt;

  // held event
  kest_key_t   item_key_r;
  logic [31:0] item_limit_r, item_window_r, item_now_r;

  // pending verdict and output register
  logic        res_pass_r, res_hit_r, res_ins_r, res_full_r;
  logic        res_pass_nxt, res_hit_nxt, res_ins_nxt, res_full_nxt;
  logic        o_pass_r, o_hit_r, o_ins_r, o_full_r;
  logic [31:0] o_total_r;

  kest_mem_req_t key_req, trk_req;
  kest_key_t     in_key;
  kest_trk_t     trk_rd, trk_wr;
  logic          match;

  logic          in_xfer, out_load;
  logic [31:0]   cnt_inc, elapsed, new_cnt;
  logic          restart, suppress;

  assign in_key   = '{key: in_key_hash, rule: in_rule_id, rev: in_rule_revision};
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  kest_key_mem u_key_mem (
    .clk     (clk),
    .req     (key_req),
    .wr_data (item_key_r),
    .cmp_key (item_key_r),
    .match   (match)
  );

  kest_trk_mem u_trk_mem (
    .clk     (clk),
    .req     (trk_req),
    .wr_data (trk_wr),
    .rd_data (trk_rd)
  );

  // hit update of the matched entry
  assign cnt_inc  = trk_rd.count + 32'd1;
  assign elapsed  = item_now_r - trk_rd.stamp;
  assign restart  = (elapsed > item_window_r) || (cnt_inc == 32'd0);
  assign new_cnt  = restart ? 32'd1 : cnt_inc;
  assign suppress = (item_limit_r < new_cnt);

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    issue_nxt    = issue_r;
    cmp_idx_nxt  = cmp_idx_r;
    total_nxt    = total_r;
    res_pass_nxt = res_pass_r;
    res_hit_nxt  = res_hit_r;
    res_ins_nxt  = res_ins_r;
    res_full_nxt = res_full_r;
    key_req      = '0;
    trk_req      = '0;
    trk_wr       = '{count: 32'd1, stamp: item_now_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          issue_nxt   = CNT_W'(1);
          cmp_idx_nxt = '0;
          if (used_r == '0) begin
            state_nxt = ST_MISS;
          end else begin
            key_req.rd_en   = 1'b1;
            key_req.rd_addr = '0;
            trk_req.rd_en   = 1'b1;
            trk_req.rd_addr = '0;
            state_nxt       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // entry cmp_idx_r is on the read port this cycle
        if (match) begin
          state_nxt = ST_UPDATE;
        end else if (issue_r == used_r) begin
          state_nxt = ST_MISS;
        end else begin
          key_req.rd_en   = 1'b1;
          key_req.rd_addr = issue_r[IDX_W-1:0];
          trk_req.rd_en   = 1'b1;
          trk_req.rd_addr = issue_r[IDX_W-1:0];
          cmp_idx_nxt     = issue_r[IDX_W-1:0];
          issue_nxt       = issue_r + CNT_W'(1);
        end
      end
      ST_UPDATE: begin
        trk_req.wr_en   = 1'b1;
        trk_req.wr_addr = cmp_idx_r;
        trk_wr.count    = new_cnt;
        trk_wr.stamp    = (restart || suppress) ? item_now_r : trk_rd.stamp;
        if (suppress) begin
          total_nxt = total_r + 32'd1;
        end
        res_pass_nxt = !suppress;
        res_hit_nxt  = 1'b1;
        res_ins_nxt  = 1'b0;
        res_full_nxt = 1'b0;
        state_nxt    = ST_EMIT;
      end
      ST_MISS: begin
        res_pass_nxt = 1'b1;
        res_hit_nxt  = 1'b0;
        if (used_r < DEPTH_C) begin
          key_req.wr_en   = 1'b1;
          key_req.wr_addr = used_r[IDX_W-1:0];
          trk_req.wr_en   = 1'b1;
          trk_req.wr_addr = used_r[IDX_W-1:0];
          used_nxt        = used_r + CNT_W'(1);
          res_ins_nxt     = 1'b1;
          res_full_nxt    = 1'b0;
        end else begin
          res_ins_nxt  = 1'b0;
          res_full_nxt = 1'b1;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      issue_r     <= '0;
      cmp_idx_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      issue_r     <= issue_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_key_r    <= in_key;
      item_limit_r  <= in_pass_limit;
      item_window_r <= in_window_seconds;
      item_now_r    <= in_now_seconds;
    end
    res_pass_r <= res_pass_nxt;
    res_hit_r  <= res_hit_nxt;
    res_ins_r  <= res_ins_nxt;
    res_full_r <= res_full_nxt;
    if (out_load) begin
      o_pass_r  <= res_pass_r;
      o_hit_r   <= res_hit_r;
      o_ins_r   <= res_ins_r;
      o_full_r  <= res_full_r;
      o_total_r <= total_r;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_pass_event           = o_pass_r;
  assign out_hit                  = o_hit_r;
  assign out_inserted             = o_ins_r;
  assign out_table_full           = o_full_r;
  assign out_suppressed_total_out = o_total_r;

  `KEST_ASSERT(a_used_bound, used_r <= DEPTH_C, "entry count beyond table depth")
  `KEST_ASSERT(a_key_wr_miss, key_req.wr_en |-> (state_r == ST_MISS),
    "key memory written outside miss handling")
  `KEST_ASSERT(a_total_only_update, (state_r != ST_UPDATE) |=> $stable(total_r),
    "suppression total changed outside hit update")
  `KEST_ASSERT(a_scan_in_range, (state_r == ST_SCAN) |-> ({1'b0, cmp_idx_r} < used_r),
    "compare index outside entries in use")
  `KEST_ASSERT(a_accept_leaves_idle, in_xfer |=> (state_r != ST_IDLE),
    "accepted event did not start a search")

endmodule

// ===== test/keyed_event_suppression_table_unit_tb.sv =====
// Self-checking bench for keyed_event_suppression_table_unit: directed rows, then random events
// scored against a behavioral table kept here. Depends on kest_pkg and the unit's RTL only.
module keyed_event_suppression_table_unit_tb;
  import kest_pkg::*;

  localparam int RANDOM_EVENTS = 1632;
  localparam int DIRECTED_ROWS = 18;
  localparam int DRAIN_CYCLES  = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PRINT_CAP     = 100;

  localparam logic [31:0] KEY_A  = 32'h1234_5678;
  localparam logic [31:0] RULE_A = 32'h0000_2001;
  localparam logic [31:0] KEY_C  = 32'hA5A5_0F0F;
  localparam logic [31:0] RULE_C = 32'h8000_0001;
  localparam logic [31:0] ALL1   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] rule;
    logic [15:0] rev;
    logic [31:0] limit;
    logic [31:0] window;
    logic [31:0] now;
  } event_t;

  typedef struct packed {
    logic        pass_ev;
    logic        hit;
    logic        ins;
    logic        no_room;
    logic [31:0] total;
  } verdict_t;

  typedef struct packed {
    event_t   ev;
    logic     typed;
    verdict_t want;
  } stim_row_t;

  localparam verdict_t NO_VERDICT = '0;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_key_hash;
  logic [31:0] in_rule_id;
  logic [15:0] in_rule_revision;
  logic [31:0] in_pass_limit;
  logic [31:0] in_window_seconds;
  logic [31:0] in_now_seconds;
  logic        out_valid;
  logic        out_ready;
  logic        out_pass_event;
  logic        out_hit;
  logic        out_inserted;
  logic        out_table_full;
  logic [31:0] out_suppressed_total_out;

  keyed_event_suppression_table_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // behavioral copy of the table
  logic [31:0] seen_key   [TABLE_DEPTH];
  logic [31:0] seen_rule  [TABLE_DEPTH];
  logic [15:0] seen_rev   [TABLE_DEPTH];
  logic [31:0] seen_count [TABLE_DEPTH];
  logic [31:0] seen_stamp [TABLE_DEPTH];
  int          seen_used = 0;
  logic [31:0] supp_total = '0;

  verdict_t awaited_verdicts[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  logic     hold_off_req = 1'b0;

  function automatic verdict_t judge_event(event_t e);
    verdict_t    v;
    int          slot;
    logic [31:0] elapsed;
    v = NO_VERDICT;
    v.pass_ev = 1'b1;
    slot = -1;
    for (int i = 0; i < seen_used; i++) begin
      if (slot < 0 && seen_key[i] == e.key && seen_rule[i] == e.rule && seen_rev[i] == e.rev)
        slot = i;
    end
    if (slot >= 0) begin
      v.hit = 1'b1;
      seen_count[slot] = seen_count[slot] + 32'd1;
      elapsed = e.now - seen_stamp[slot];
      // expired window or wrapped count restarts the run
      if (elapsed > e.window || seen_count[slot] == '0) begin
        seen_count[slot] = 32'd1;
        seen_stamp[slot] = e.now;
      end
      if (e.limit < seen_count[slot]) begin
        seen_stamp[slot] = e.now;
        v.pass_ev = 1'b0;
        supp_total = supp_total + 32'd1;
      end
    end else if (seen_used < TABLE_DEPTH) begin
      seen_key[seen_used]   = e.key;
      seen_rule[seen_used]  = e.rule;
      seen_rev[seen_used]   = e.rev;
      seen_count[seen_used] = 32'd1;
      seen_stamp[seen_used] = e.now;
      seen_used++;
      v.ins = 1'b1;
    end else begin
      v.no_room = 1'b1;
    end
    v.total = supp_total;
    return v;
  endfunction

  function automatic stim_row_t directed_row(int n);
    stim_row_t r;
    r = '0;
    case (n)
      0:  r = '{'{KEY_A, RULE_A, 16'h0000, 32'd0, 32'd10, 32'd100}, 1'b1,
                '{1'b1, 1'b0, 1'b1, 1'b0, 32'd0}};
      1:  r = '{'{KEY_A, RULE_A, 16'h0000, 32'd0, 32'd10, 32'd101}, 1'b1,
                '{1'b0, 1'b1, 1'b0, 1'b0, 32'd1}};
      // time runs backwards: huge elapsed restarts, zero limit still suppresses
      2:  r = '{'{KEY_A, RULE_A, 16'h0000, 32'd0, 32'd10, 32'd0}, 1'b0, NO_VERDICT};
      3:  r = '{'{KEY_A, RULE_A, 16'h0001, 32'd5, 32'd10, 32'd3}, 1'b0, NO_VERDICT};
      4:  r = '{'{KEY_A, RULE_A ^ 32'd3, 16'h0000, 32'd5, 32'd10, 32'd4}, 1'b0, NO_VERDICT};
      5:  r = '{'{KEY_A ^ 32'd1, RULE_A, 16'h0000, 32'd5, 32'd10, 32'd5}, 1'b0, NO_VERDICT};
      6:  r = '{'{ALL1, ALL1, 16'hFFFF, ALL1, ALL1, ALL1}, 1'b1,
                '{1'b1, 1'b0, 1'b1, 1'b0, 32'd2}};
      7:  r = '{'{ALL1, ALL1, 16'hFFFF, ALL1, ALL1, 32'd0}, 1'b0, NO_VERDICT};
      8:  r = '{'{ALL1, ALL1, 16'hFFFF, 32'd1, ALL1, 32'd0}, 1'b0, NO_VERDICT};
      9:  r = '{'{32'd0, 32'd0, 16'h0000, 32'd1, 32'd0, 32'd5}, 1'b0, NO_VERDICT};
      10: r = '{'{32'd0, 32'd0, 16'h0000, 32'd1, 32'd0, 32'd5}, 1'b0, NO_VERDICT};
      11: r = '{'{32'd0, 32'd0, 16'h0000, 32'd1, 32'd0, 32'd6}, 1'b0, NO_VERDICT};
      // window straddles the 2^32 wrap of the seconds counter
      12: r = '{'{KEY_C, RULE_C, 16'h8000, 32'd2, 32'd5, 32'hFFFF_FFFE}, 1'b0, NO_VERDICT};
      13: r = '{'{KEY_C, RULE_C, 16'h8000, 32'd2, 32'd5, 32'd2}, 1'b0, NO_VERDICT};
      14: r = '{'{KEY_C, RULE_C, 16'h8000, 32'd2, 32'd5, 32'd3}, 1'b0, NO_VERDICT};
      15: r = '{'{KEY_C, RULE_C, 16'h8000, 32'd2, 32'd5, 32'd8}, 1'b0, NO_VERDICT};
      16: r = '{'{KEY_C, RULE_C, 16'h8000, 32'd2, 32'd5, 32'd14}, 1'b0, NO_VERDICT};
      17: r = '{'{KEY_A, RULE_A, 16'h0000, ALL1, ALL1, 32'd200}, 1'b0, NO_VERDICT};
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("[%0d] %s: got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic offer_event(event_t e, logic typed, verdict_t want);
    verdict_t v;
    in_valid          = 1'b1;
    in_key_hash       = e.key;
    in_rule_id        = e.rule;
    in_rule_revision  = e.rev;
    in_pass_limit     = e.limit;
    in_window_seconds = e.window;
    in_now_seconds    = e.now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    v = judge_event(e);
    awaited_verdicts.push_back(typed ? want : v);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin : score_blk
    verdict_t got;
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_pass_event, out_hit, out_inserted, out_table_full, out_suppressed_total_out};
      if (awaited_verdicts.size() == 0) begin
        flag_mismatch("verdict with nothing awaited", 32'(got.pass_ev), 32'd0);
      end else begin
        want = awaited_verdicts.pop_front();
        if (got.pass_ev !== want.pass_ev)
          flag_mismatch("pass_event", 32'(got.pass_ev), 32'(want.pass_ev));
        if (got.hit !== want.hit)
          flag_mismatch("hit", 32'(got.hit), 32'(want.hit));
        if (got.ins !== want.ins)
          flag_mismatch("inserted", 32'(got.ins), 32'(want.ins));
        if (got.no_room !== want.no_room)
          flag_mismatch("table_full", 32'(got.no_room), 32'(want.no_room));
        if (got.total !== want.total)
          flag_mismatch("suppressed_total_out", got.total, want.total);
      end
    end
  end

  // receiver: rotates between always ready, coin-flip and periodic patterns
  initial begin : sink_blk
    int   mode;
    int   mode_left;
    int   period;
    int   phase;
    logic held_off;
    mode = 0;
    mode_left = 0;
    period = 2;
    phase = 0;
    held_off = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req && !held_off) begin
        held_off = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(40, 300);
        period    = $urandom_range(2, 5);
      end
      mode_left--;
      phase++;
      case (mode)
        0:       out_ready = 1'b1;
        1:       out_ready = $urandom_range(0, 1);
        default: out_ready = (phase % period == 0);
      endcase
    end
  end

  initial begin : source_blk
    stim_row_t   row;
    event_t      e;
    logic [31:0] clock_s;
    int          burst_left;
    int          gap;
    int          pick;
    int          hot_base;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_key_hash       = '0;
    in_rule_id        = '0;
    in_rule_revision  = '0;
    in_pass_limit     = '0;
    in_window_seconds = '0;
    in_now_seconds    = '0;
    clock_s    = $urandom;
    burst_left = $urandom_range(1, 20);
    hot_base   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int n = 0; n < DIRECTED_ROWS + RANDOM_EVENTS; n++) begin
      if (n < DIRECTED_ROWS) begin
        row = directed_row(n);
      end else begin
        // block fills while the receiver holds off
        if (n == DIRECTED_ROWS) hold_off_req = 1'b1;
        if ($urandom_range(0, 39) == 0) clock_s = $urandom;
        else clock_s = clock_s + 32'($urandom_range(0, 3));
        if ($urandom_range(0, 59) == 0 && seen_used > 4) hot_base = $urandom_range(0, seen_used - 4);
        e = '0;
        if (seen_used == 0 || $urandom_range(0, 11) == 0) begin
          if (seen_used > 0 && $urandom_range(0, 1) == 1) begin
            // near miss: one field of a stored key differs in one bit
            pick = $urandom_range(0, seen_used - 1);
            e.key  = seen_key[pick];
            e.rule = seen_rule[pick];
            e.rev  = seen_rev[pick];
            case ($urandom_range(0, 2))
              0:       e.key  = e.key ^ (32'd1 << $urandom_range(0, 31));
              1:       e.rule = e.rule ^ (32'd1 << $urandom_range(0, 31));
              default: e.rev  = e.rev ^ (16'd1 << $urandom_range(0, 15));
            endcase
          end else begin
            e.key  = $urandom;
            e.rule = $urandom;
            e.rev  = 16'($urandom);
          end
        end else begin
          if ($urandom_range(0, 1) == 1 && seen_used > hot_base)
            pick = $urandom_range(hot_base, (hot_base + 3 < seen_used) ? hot_base + 3
                                                                     : seen_used - 1);
          else
            pick = $urandom_range(0, seen_used - 1);
          e.key  = seen_key[pick];
          e.rule = seen_rule[pick];
          e.rev  = seen_rev[pick];
        end
        case ($urandom_range(0, 9))
          0:       e.limit = '0;
          1:       e.limit = ALL1;
          2:       e.limit = $urandom;
          default: e.limit = 32'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 9))
          0:       e.window = '0;
          1:       e.window = ALL1;
          2:       e.window = $urandom;
          default: e.window = 32'($urandom_range(0, 60));
        endcase
        e.now = clock_s;
        row = '{e, 1'b0, NO_VERDICT};
      end
      offer_event(row.ev, row.typed, row.want);
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
    in_valid = 1'b0;

    while (awaited_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
